@@ rtl/ttwb_pkg.sv @@
// ----------------------------------------------------------------------------
// ttwb_pkg: shared definitions for the triangle transform block
// Default widths, vector geometry, matrix layout and item codes.
// ----------------------------------------------------------------------------
package ttwb_pkg;

  // Default number format: signed Q16.16
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Vector and matrix geometry
  localparam int NUM_COMP   = 4;
  localparam int NUM_COEF   = 32;
  localparam int COEF_IDX_W = 5;
  localparam int INV_BASE   = 16;

  // Input item codes
  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_CORNER = 1'b1;

  // Result item codes
  localparam logic KIND_CORNER = 1'b0;
  localparam logic KIND_BOX    = 1'b1;

endpackage

@@ rtl/ttwb_intf.sv @@
// ----------------------------------------------------------------------------
// ttwb channel interfaces
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
interface ttwb_in_if #(
  parameter int DATA_WIDTH = ttwb_pkg::DATA_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [ttwb_pkg::COEF_IDX_W-1:0]     coef_index;
  logic signed [DATA_WIDTH-1:0]        coef_value;
  logic signed [DATA_WIDTH-1:0]        vertex_x;
  logic signed [DATA_WIDTH-1:0]        vertex_y;
  logic signed [DATA_WIDTH-1:0]        vertex_z;
  logic signed [DATA_WIDTH-1:0]        vertex_w;
  logic signed [DATA_WIDTH-1:0]        normal_x;
  logic signed [DATA_WIDTH-1:0]        normal_y;
  logic signed [DATA_WIDTH-1:0]        normal_z;
  logic signed [DATA_WIDTH-1:0]        normal_w;

  modport source (
    output valid, op, coef_index, coef_value,
    output vertex_x, vertex_y, vertex_z, vertex_w,
    output normal_x, normal_y, normal_z, normal_w,
    input  ready
  );
  modport sink (
    input  valid, op, coef_index, coef_value,
    input  vertex_x, vertex_y, vertex_z, vertex_w,
    input  normal_x, normal_y, normal_z, normal_w,
    output ready
  );
endinterface

interface ttwb_out_if #(
  parameter int DATA_WIDTH = ttwb_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [DATA_WIDTH-1:0] pos_or_min_x;
  logic signed [DATA_WIDTH-1:0] pos_or_min_y;
  logic signed [DATA_WIDTH-1:0] pos_or_min_z;
  logic signed [DATA_WIDTH-1:0] pos_or_min_w;
  logic signed [DATA_WIDTH-1:0] norm_or_max_x;
  logic signed [DATA_WIDTH-1:0] norm_or_max_y;
  logic signed [DATA_WIDTH-1:0] norm_or_max_z;
  logic signed [DATA_WIDTH-1:0] norm_or_max_w;
  logic                         last;

  modport source (
    output valid, kind, last,
    output pos_or_min_x, pos_or_min_y, pos_or_min_z, pos_or_min_w,
    output norm_or_max_x, norm_or_max_y, norm_or_max_z, norm_or_max_w,
    input  ready
  );
  modport sink (
    input  valid, kind, last,
    input  pos_or_min_x, pos_or_min_y, pos_or_min_z, pos_or_min_w,
    input  norm_or_max_x, norm_or_max_y, norm_or_max_z, norm_or_max_w,
    output ready
  );
endinterface

interface ttwb_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/triangle_transform_with_bounds.sv @@
// ----------------------------------------------------------------------------
// triangle_transform_with_bounds: corner transform with triangle bounding box
// Eight row lanes transform vertex and normal; a merge stage adds the box.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the pipeline advances. A coefficient
// transaction writes the matrix register file at once and gives no result.
// A corner transaction runs through an input register, three lane stages
// (partial products, products, sum with floor scaling and saturation) and
// the output register. Every third corner of a triangle gives a second
// result, the bounding box, which holds the lanes while it waits for the
// single result port; so even with the result channel always ready, a
// stream of corners cannot run at the full rate. No clearing pass is needed
// after reset. force_w_r is written through the configuration channel,
// which is always ready.
// ----------------------------------------------------------------------------
module triangle_transform_with_bounds #(
  parameter int DATA_WIDTH = ttwb_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ttwb_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ttwb_cfg_if.sink    cfg_ch,
  ttwb_in_if.sink     in_ch,
  ttwb_out_if.source  out_ch
);

  localparam int N = ttwb_pkg::NUM_COMP;

  localparam logic signed [DATA_WIDTH-1:0] UNIT_W = DATA_WIDTH'(1) << FRAC_BITS;

  logic                         force_w_r;
  logic signed [DATA_WIDTH-1:0] mat_r [ttwb_pkg::NUM_COEF];
  logic signed [DATA_WIDTH-1:0] vtx_r [N];
  logic signed [DATA_WIDTH-1:0] nrm_r [N];
  logic                         a_valid_r;
  logic                         p1_valid_r;
  logic                         p2_valid_r;
  logic                         p3_valid_r;
  logic                         adv;
  logic                         in_take;
  logic signed [DATA_WIDTH-1:0] tv [N];
  logic signed [DATA_WIDTH-1:0] tn [N];

  // Configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_w_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      force_w_r <= cfg_ch.data;
    end
  end

  // Input handshake follows the pipeline advance
  assign in_ch.ready = adv;
  assign in_take     = in_ch.valid && adv;

  // Coefficient register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ttwb_pkg::NUM_COEF; i++) begin
        mat_r[i] <= '0;
      end
    end else if (in_take && (in_ch.op == ttwb_pkg::OP_COEF)) begin
      mat_r[in_ch.coef_index] <= in_ch.coef_value;
    end
  end

  // Valid chain alongside the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r  <= in_ch.valid && (in_ch.op == ttwb_pkg::OP_CORNER);
      p1_valid_r <= a_valid_r;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
    end
  end

  // Capture the corner operands, substituting unit w when forced
  always_ff @(posedge clk) begin
    if (adv) begin
      vtx_r[0] <= in_ch.vertex_x;
      vtx_r[1] <= in_ch.vertex_y;
      vtx_r[2] <= in_ch.vertex_z;
      vtx_r[3] <= force_w_r ? UNIT_W : in_ch.vertex_w;
      nrm_r[0] <= in_ch.normal_x;
      nrm_r[1] <= in_ch.normal_y;
      nrm_r[2] <= in_ch.normal_z;
      nrm_r[3] <= force_w_r ? UNIT_W : in_ch.normal_w;
    end
  end

  // One lane per output row: model matrix on the vertex, inverse on the normal
  for (genvar r = 0; r < N; r++) begin : g_row
    logic signed [DATA_WIDTH-1:0] vcoef [N];
    logic signed [DATA_WIDTH-1:0] ncoef [N];

    for (genvar c = 0; c < N; c++) begin : g_col
      assign vcoef[c] = mat_r[r * N + c];
      assign ncoef[c] = mat_r[ttwb_pkg::INV_BASE + r * N + c];
    end

    ttwb_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_vtx_lane (
      .clk    (clk),
      .en     (adv),
      .coef   (vcoef),
      .opnd   (vtx_r),
      .result (tv[r])
    );

    ttwb_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_nrm_lane (
      .clk    (clk),
      .en     (adv),
      .coef   (ncoef),
      .opnd   (nrm_r),
      .result (tn[r])
    );
  end

  // Merge lane results, track the box, drive results
  ttwb_merge #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (p3_valid_r),
    .tv         (tv),
    .tn         (tn),
    .adv        (adv),
    .out_ch     (out_ch)
  );

endmodule

@@ rtl/ttwb_lane.sv @@
// ----------------------------------------------------------------------------
// ttwb_lane: one matrix row times one vector
// Three-stage pipelined dot product of four signed fixed-point terms with
// floor scaling and saturation to the data width.
// ----------------------------------------------------------------------------
module ttwb_lane #(
  parameter int DATA_WIDTH = ttwb_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ttwb_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH-1:0] coef   [ttwb_pkg::NUM_COMP],
  input  logic signed [DATA_WIDTH-1:0] opnd   [ttwb_pkg::NUM_COMP],
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int N      = ttwb_pkg::NUM_COMP;
  localparam int LO_W   = DATA_WIDTH / 2;
  localparam int HI_W   = DATA_WIDTH - LO_W;
  localparam int PL_W   = DATA_WIDTH + LO_W + 1;
  localparam int PH_W   = DATA_WIDTH + HI_W;
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int UP_W   = SUM_W - DATA_WIDTH + 1;

  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [PL_W-1:0]       pl_nxt   [N];
  logic signed [PL_W-1:0]       pl_r     [N];
  logic signed [PH_W-1:0]       ph_nxt   [N];
  logic signed [PH_W-1:0]       ph_r     [N];
  logic signed [PROD_W-1:0]     prod_nxt [N];
  logic signed [PROD_W-1:0]     prod_r   [N];
  logic signed [SUM_W-1:0]      sum;
  logic signed [SUM_W-1:0]      scaled;
  logic [UP_W-1:0]              upper;
  logic signed [DATA_WIDTH-1:0] result_nxt;
  logic signed [DATA_WIDTH-1:0] result_r;

  // Split each operand into an unsigned low half and a signed high half
  always_comb begin
    for (int c = 0; c < N; c++) begin
      pl_nxt[c] = PL_W'(coef[c]) * PL_W'($signed({1'b0, opnd[c][LO_W-1:0]}));
      ph_nxt[c] = PH_W'(coef[c]) * PH_W'($signed(opnd[c][DATA_WIDTH-1:LO_W]));
    end
  end

  // Recombine the partial products into full products
  always_comb begin
    for (int c = 0; c < N; c++) begin
      prod_nxt[c] = (PROD_W'(ph_r[c]) <<< LO_W) + PROD_W'(pl_r[c]);
    end
  end

  // Sum the row, scale with floor, saturate
  always_comb begin
    sum = '0;
    for (int c = 0; c < N; c++) begin
      sum = sum + SUM_W'(prod_r[c]);
    end
    scaled = sum >>> FRAC_BITS;
    upper  = scaled[SUM_W-1:DATA_WIDTH-1];
    if ((&upper) || (~|upper)) begin
      result_nxt = scaled[DATA_WIDTH-1:0];
    end else if (sum[SUM_W-1]) begin
      result_nxt = SAT_MIN;
    end else begin
      result_nxt = SAT_MAX;
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < N; c++) begin
        pl_r[c]   <= pl_nxt[c];
        ph_r[c]   <= ph_nxt[c];
        prod_r[c] <= prod_nxt[c];
      end
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

@@ rtl/ttwb_merge.sv @@
// ----------------------------------------------------------------------------
// ttwb_merge: result merging and bounding box
// Collects the lane results of one corner, tracks the running box of the
// current triangle and drives the result channel from an output register.
// ----------------------------------------------------------------------------
module ttwb_merge #(
  parameter int DATA_WIDTH = ttwb_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         lane_valid,
  input  logic signed [DATA_WIDTH-1:0] tv [ttwb_pkg::NUM_COMP],
  input  logic signed [DATA_WIDTH-1:0] tn [ttwb_pkg::NUM_COMP],
  output logic                         adv,
  ttwb_out_if.source                   out_ch
);

  localparam int N = ttwb_pkg::NUM_COMP;

  logic [1:0]                   cnt_r;
  logic signed [DATA_WIDTH-1:0] min_r   [N];
  logic signed [DATA_WIDTH-1:0] max_r   [N];
  logic signed [DATA_WIDTH-1:0] min_nxt [N];
  logic signed [DATA_WIDTH-1:0] max_nxt [N];
  logic                         out_valid_r;
  logic                         kind_r;
  logic                         last_r;
  logic signed [DATA_WIDTH-1:0] pos_r   [N];
  logic signed [DATA_WIDTH-1:0] nrm_r   [N];
  logic                         box_pend_r;
  logic                         out_free;
  logic                         take;
  logic                         first;
  logic                         third;

  // Output slot and corner take-over
  assign out_free = !out_valid_r || out_ch.ready;
  assign take     = lane_valid && out_free && !box_pend_r;
  assign adv      = !lane_valid || take;
  assign first    = (cnt_r == 2'd0);
  assign third    = (cnt_r >= 2'd2);

  // Update the running box with the new corner
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (first || (tv[i] < min_r[i])) begin
        min_nxt[i] = tv[i];
      end else begin
        min_nxt[i] = min_r[i];
      end
      if (first || (tv[i] > max_r[i])) begin
        max_nxt[i] = tv[i];
      end else begin
        max_nxt[i] = max_r[i];
      end
    end
  end

  // Hold counter, box and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
      box_pend_r  <= 1'b0;
      for (int i = 0; i < N; i++) begin
        min_r[i] <= '0;
        max_r[i] <= '0;
      end
    end else begin
      if (take) begin
        cnt_r <= third ? 2'd0 : 2'(cnt_r + 2'd1);
        for (int i = 0; i < N; i++) begin
          min_r[i] <= min_nxt[i];
          max_r[i] <= max_nxt[i];
        end
      end
      if (out_free) begin
        if (box_pend_r) begin
          out_valid_r <= 1'b1;
          box_pend_r  <= 1'b0;
          kind_r      <= ttwb_pkg::KIND_BOX;
          last_r      <= 1'b1;
          for (int i = 0; i < N; i++) begin
            pos_r[i] <= min_r[i];
            nrm_r[i] <= max_r[i];
          end
        end else if (lane_valid) begin
          out_valid_r <= 1'b1;
          box_pend_r  <= third;
          kind_r      <= ttwb_pkg::KIND_CORNER;
          last_r      <= !third;
          for (int i = 0; i < N; i++) begin
            pos_r[i] <= tv[i];
            nrm_r[i] <= tn[i];
          end
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  // Drive the result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.last          = last_r;
  assign out_ch.pos_or_min_x  = pos_r[0];
  assign out_ch.pos_or_min_y  = pos_r[1];
  assign out_ch.pos_or_min_z  = pos_r[2];
  assign out_ch.pos_or_min_w  = pos_r[3];
  assign out_ch.norm_or_max_x = nrm_r[0];
  assign out_ch.norm_or_max_y = nrm_r[1];
  assign out_ch.norm_or_max_z = nrm_r[2];
  assign out_ch.norm_or_max_w = nrm_r[3];

endmodule

@@ tb/sv/triangle_transform_with_bounds_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_transform_with_bounds_tb: self-checking bench for the corner block
// Streams coefficient and corner transactions with random gaps and stalls,
// predicts every transformed corner and triangle box in Q16.16 with floor
// scaling and saturation, and checks each result against that prediction.
// ----------------------------------------------------------------------------
localparam int DW    = ttwb_pkg::DATA_WIDTH_DEF;
localparam int FB    = ttwb_pkg::FRAC_BITS_DEF;
localparam int ACC_W = 2 * DW + 4;

typedef logic [ttwb_pkg::NUM_COMP-1:0][DW-1:0] q_vec_t;

typedef struct packed {
  logic                            op;
  logic [ttwb_pkg::COEF_IDX_W-1:0] coef_index;
  logic [DW-1:0]                   coef_value;
  q_vec_t                          vtx;
  q_vec_t                          nrm;
} corner_item_t;

typedef struct packed {
  logic   kind;
  q_vec_t pos_min;
  q_vec_t norm_max;
  logic   last;
} corner_result_t;

class corner_scoreboard;
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic [DW-1:0]  coef [ttwb_pkg::NUM_COEF];
  int unsigned    corners_taken;
  q_vec_t         box_lo;
  q_vec_t         box_hi;
  bit             unit_w;
  corner_result_t pending_results[$];
  int unsigned    mismatches;

  function new();
    foreach (coef[i]) coef[i] = '0;
    corners_taken = 0;
    box_lo        = '0;
    box_hi        = '0;
    unit_w        = 1'b0;
    mismatches    = 0;
  endfunction

  function void set_unit_w(bit value);
    unit_w = value;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // One matrix row times a vector: exact sum, floor by FB bits, saturate
  function logic [DW-1:0] transform_row(int unsigned base, int unsigned row, q_vec_t vec);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] m;
    logic signed [ACC_W-1:0] x;
    acc = '0;
    for (int c = 0; c < ttwb_pkg::NUM_COMP; c++) begin
      m   = $signed(coef[base + row * ttwb_pkg::NUM_COMP + c]);
      x   = $signed(vec[c]);
      acc = acc + m * x;
    end
    acc = acc >>> FB;
    if (acc > SAT_HI) return SAT_HI[DW-1:0];
    if (acc < SAT_LO) return SAT_LO[DW-1:0];
    return acc[DW-1:0];
  endfunction

  function void note_item(corner_item_t it);
    q_vec_t         vin;
    q_vec_t         nin;
    q_vec_t         tv;
    q_vec_t         tn;
    bit             closes;
    corner_result_t res;
    if (it.op == ttwb_pkg::OP_COEF) begin
      coef[it.coef_index] = it.coef_value;
      return;
    end
    vin = it.vtx;
    nin = it.nrm;
    if (unit_w) begin
      vin[ttwb_pkg::NUM_COMP-1] = DW'(1) << FB;
      nin[ttwb_pkg::NUM_COMP-1] = DW'(1) << FB;
    end
    for (int r = 0; r < ttwb_pkg::NUM_COMP; r++) begin
      tv[r] = transform_row(0, r, vin);
      tn[r] = transform_row(ttwb_pkg::INV_BASE, r, nin);
    end
    // Track the running box of the current triangle
    for (int i = 0; i < ttwb_pkg::NUM_COMP; i++) begin
      if (corners_taken == 0) begin
        box_lo[i] = tv[i];
        box_hi[i] = tv[i];
      end else begin
        if ($signed(tv[i]) < $signed(box_lo[i])) box_lo[i] = tv[i];
        if ($signed(tv[i]) > $signed(box_hi[i])) box_hi[i] = tv[i];
      end
    end
    closes        = corners_taken >= 2;
    corners_taken = closes ? 0 : corners_taken + 1;
    res.kind     = ttwb_pkg::KIND_CORNER;
    res.pos_min  = tv;
    res.norm_max = tn;
    res.last     = !closes;
    pending_results.push_back(res);
    if (closes) begin
      res.kind     = ttwb_pkg::KIND_BOX;
      res.pos_min  = box_lo;
      res.norm_max = box_hi;
      res.last     = 1'b1;
      pending_results.push_back(res);
    end
  endfunction

  function void check_result(corner_result_t got);
    corner_result_t want;
    bit             bad;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected result: kind %0d last %0d pos/min %h norm/max %h",
                 $time, got.kind, got.last, got.pos_min, got.norm_max);
      return;
    end
    want = pending_results.pop_front();
    bad  = (got.kind !== want.kind) || (got.last !== want.last);
    for (int i = 0; i < ttwb_pkg::NUM_COMP; i++) begin
      if (got.pos_min[i] !== want.pos_min[i]) bad = 1'b1;
      if (got.norm_max[i] !== want.norm_max[i]) bad = 1'b1;
    end
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] result mismatch", $time);
        $display("  expected kind %0d last %0d pos/min %h norm/max %h",
                 want.kind, want.last, want.pos_min, want.norm_max);
        $display("  actual   kind %0d last %0d pos/min %h norm/max %h",
                 got.kind, got.last, got.pos_min, got.norm_max);
      end
    end
  endfunction
endclass

module triangle_transform_with_bounds_tb;

  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          HOLD_CYCLES   = 200;
  localparam int          PHASES        = 7;
  localparam int          PHASE_CORNERS = 200;

  localparam logic [DW-1:0] Q_ZERO    = '0;
  localparam logic [DW-1:0] Q_ONE     = DW'(1) << FB;
  localparam logic [DW-1:0] Q_HALF    = Q_ONE >> 1;
  localparam logic [DW-1:0] Q_NEG_ONE = ~Q_ONE + 1'b1;
  localparam logic [DW-1:0] Q_MAX     = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] Q_MIN     = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] Q_RAW_M1  = '1;

  logic clk;
  logic rst_n;

  ttwb_cfg_if                      cfg_ch ();
  ttwb_in_if  #(.DATA_WIDTH(DW))   in_ch ();
  ttwb_out_if #(.DATA_WIDTH(DW))   out_ch ();

  triangle_transform_with_bounds #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  corner_scoreboard sb = new();

  bit             quiet;         // no idling on either side
  bit             eager;         // sender offers back to back
  bit             hold_request;  // ask the receiver for a long hold-off
  int             hold_left;
  int             stretch_left;
  bit             ready_level;
  int unsigned    cycle_count;
  corner_item_t   seen_item;
  corner_result_t seen_result;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Q16.16 value: mode 0 small, 1 medium, 2 full range; extremes mixed in
  function automatic logic [DW-1:0] rand_q(int mode);
    logic [DW-1:0] v;
    int            r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 5))
        0:       v = Q_MAX;
        1:       v = Q_MIN;
        2:       v = Q_ZERO;
        3:       v = Q_ONE;
        4:       v = Q_NEG_ONE;
        default: v = Q_RAW_M1;
      endcase
    end else if (mode == 0 || r < 50) begin
      v = $urandom_range(0, 'h20_0000);
      v = v - 'h10_0000;
    end else if (mode == 1 || r < 75) begin
      v = $urandom;
      v = $signed(v) >>> 8;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic q_vec_t rand_vec(int mode);
    q_vec_t v;
    for (int i = 0; i < ttwb_pkg::NUM_COMP; i++) v[i] = rand_q(mode);
    return v;
  endfunction

  function automatic q_vec_t make_vec(logic [DW-1:0] x, logic [DW-1:0] y,
                                      logic [DW-1:0] z, logic [DW-1:0] w);
    return {w, z, y, x};
  endfunction

  // Receiver: random ready stretches, a counted hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    hold_left    = 0;
    stretch_left = 0;
    ready_level  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (stretch_left > 0) begin
          stretch_left--;
        end else begin
          ready_level  = $urandom_range(0, 99) < 75;
          stretch_left = pick_gap();
        end
        out_ch.ready <= ready_level;
      end
    end
  end

  // Note accepted input transactions
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_item.op         = in_ch.op;
      seen_item.coef_index = in_ch.coef_index;
      seen_item.coef_value = in_ch.coef_value;
      seen_item.vtx        = {in_ch.vertex_w, in_ch.vertex_z, in_ch.vertex_y, in_ch.vertex_x};
      seen_item.nrm        = {in_ch.normal_w, in_ch.normal_z, in_ch.normal_y, in_ch.normal_x};
      sb.note_item(seen_item);
    end
  end

  // Check accepted result transactions
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_result.kind     = out_ch.kind;
      seen_result.pos_min  = {out_ch.pos_or_min_w, out_ch.pos_or_min_z,
                              out_ch.pos_or_min_y, out_ch.pos_or_min_x};
      seen_result.norm_max = {out_ch.norm_or_max_w, out_ch.norm_or_max_z,
                              out_ch.norm_or_max_y, out_ch.norm_or_max_x};
      seen_result.last     = out_ch.last;
      sb.check_result(seen_result);
    end
  end

  // Track configuration writes
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) sb.set_unit_w(cfg_ch.data);
  end

  // Offer one transaction after a random gap and hold it until taken
  task automatic drive_item(corner_item_t it);
    int gap;
    gap = (quiet || eager) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= it.op;
    in_ch.coef_index <= it.coef_index;
    in_ch.coef_value <= it.coef_value;
    in_ch.vertex_x   <= it.vtx[0];
    in_ch.vertex_y   <= it.vtx[1];
    in_ch.vertex_z   <= it.vtx[2];
    in_ch.vertex_w   <= it.vtx[3];
    in_ch.normal_x   <= it.nrm[0];
    in_ch.normal_y   <= it.nrm[1];
    in_ch.normal_z   <= it.nrm[2];
    in_ch.normal_w   <= it.nrm[3];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Coefficient write; the corner fields carry junk
  task automatic send_coef(int unsigned idx, logic [DW-1:0] value);
    corner_item_t it;
    it.op         = ttwb_pkg::OP_COEF;
    it.coef_index = idx[ttwb_pkg::COEF_IDX_W-1:0];
    it.coef_value = value;
    it.vtx        = rand_vec(2);
    it.nrm        = rand_vec(2);
    drive_item(it);
  endtask

  // Corner; the coefficient fields carry junk
  task automatic send_corner(q_vec_t vtx, q_vec_t nrm);
    corner_item_t it;
    int unsigned  junk_idx;
    junk_idx      = $urandom_range(0, ttwb_pkg::NUM_COEF - 1);
    it.op         = ttwb_pkg::OP_CORNER;
    it.coef_index = junk_idx[ttwb_pkg::COEF_IDX_W-1:0];
    it.coef_value = $urandom;
    it.vtx        = vtx;
    it.nrm        = nrm;
    drive_item(it);
  endtask

  // Drop valid, wait for every expected result, then let the pipe settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(bit value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int mode;
    quiet        = 1'b0;
    eager        = 1'b0;
    hold_request = 1'b0;
    rst_n            <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= ttwb_pkg::OP_COEF;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    in_ch.vertex_x   <= '0;
    in_ch.vertex_y   <= '0;
    in_ch.vertex_z   <= '0;
    in_ch.vertex_w   <= '0;
    in_ch.normal_x   <= '0;
    in_ch.normal_y   <= '0;
    in_ch.normal_z   <= '0;
    in_ch.normal_w   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner against the all-zero matrices left by reset
    send_corner(make_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX), make_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));

    // Sparse matrices: translation, saturating rows, half-step normal translation
    send_coef(0, Q_ONE);
    send_coef(3, Q_ONE << 1);
    send_coef(5, Q_MAX);
    send_coef(10, Q_MIN);
    send_coef(15, Q_ONE);
    send_coef(ttwb_pkg::INV_BASE + 0, Q_ONE);
    send_coef(ttwb_pkg::INV_BASE + 3, Q_HALF);
    send_coef(ttwb_pkg::INV_BASE + 5, Q_NEG_ONE);
    send_coef(ttwb_pkg::INV_BASE + 10, Q_MAX);
    send_coef(ttwb_pkg::NUM_COEF - 1, Q_MIN);

    // Saturation both ways, closing the triangle started above
    send_corner(make_vec(Q_MAX, Q_MAX, Q_MAX, Q_ONE), make_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_corner(make_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN), make_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));

    // Fresh triangle; floor of negative fractions on the normal
    send_corner(make_vec(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO),
                make_vec(Q_ONE, Q_NEG_ONE, Q_HALF, Q_ZERO));
    send_corner(make_vec(DW'(1), DW'(2), DW'(3), DW'(4)),
                make_vec(Q_RAW_M1, Q_ZERO, Q_ZERO, Q_RAW_M1));
    send_corner(make_vec(Q_ONE, Q_NEG_ONE, Q_ONE, Q_NEG_ONE),
                make_vec(Q_HALF, Q_HALF, Q_NEG_ONE, Q_MAX));

    // Unit w: given w values must be ignored, normals translate
    wait_idle();
    cfg_write(1'b1);
    send_corner(make_vec(Q_ONE, Q_MAX, Q_MIN, Q_MIN), make_vec(Q_RAW_M1, Q_ONE, Q_ZERO, Q_MAX));
    send_corner(make_vec(Q_NEG_ONE, Q_ZERO, Q_ONE, Q_MAX), rand_vec(0));
    send_corner(rand_vec(1), make_vec(Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN));
    wait_idle();
    cfg_write(1'b0);

    // Random phases: reload both matrices, then stream corners
    for (int phase = 0; phase < PHASES; phase++) begin
      mode = phase % 3;
      wait_idle();
      cfg_write(phase % 2 == 1);
      quiet = (phase == 2);
      eager = (phase == 4);
      for (int idx = 0; idx < ttwb_pkg::NUM_COEF; idx++) send_coef(idx, rand_q(mode));
      if (eager) hold_request = 1'b1;
      for (int n = 0; n < PHASE_CORNERS; n++) begin
        // Stray coefficient update between corners, also in the middle of a triangle
        if ($urandom_range(0, 99) < 6)
          send_coef($urandom_range(0, ttwb_pkg::NUM_COEF - 1), rand_q(mode));
        send_corner(rand_vec(mode), rand_vec(mode));
      end
      quiet = 1'b0;
      eager = 1'b0;
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
